// ----- rtl/sss_pkg.sv -----
// Shared types and constants for the halving-distance scatter step scheduler.
package sss_pkg;

    localparam int MAX_RANKS     = 64;
    localparam int RANK_ID_WIDTH = 16;
    localparam int POS_W         = $clog2(MAX_RANKS);
    localparam int SIZE_W        = POS_W + 1;
    localparam int STEP_W        = 3;
    localparam int SLICE_W       = 6;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = SIZE_W;
    localparam int UNIT_W        = 13;
    localparam int MAX_SLICES    = 32;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_RANK_SIZE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MY_RANK   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROOT_RANK = 2'd2;

    typedef enum logic [1:0] {
        KIND_IDLE = 2'd0,
        KIND_SEND = 2'd1,
        KIND_RECV = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_MY,
        ST_RED_ROOT,
        ST_DOUBLE,
        ST_DIST,
        ST_PEER,
        ST_LOOK,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/scatter_step_schedule.sv -----
// Top level of the halving-distance scatter step scheduler.
// A load beat (tuser 0) writes one rank table entry. A step beat (tuser 1) is scheduled by
// one shared compare-and-subtract unit under a small sequencer: it reduces this rank's
// position modulo the rank count, then the root's position, doubles the distance modulo the
// rank count, then computes the root distance, the peer position with its table read, and
// captures the peer. Results then leave one per cycle while the output is not stalled,
// max(slices,1) of them, where slices is at most 32. A step beat keeps the input stalled
// until its last result enters the output register. The last result waits in the output
// register while the next beat is taken.
module scatter_step_schedule (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [sss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: step_number[2:0], step_count[5:3], entry_position[11:6], entry_rank[27:12]
    input  logic [31:0]                        s_axis_tdata,
    // tuser: action
    input  logic                               s_axis_tuser,
    // Output stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: peer_rank[15:0], slice_index[21:16], slice_count[27:22]
    output logic [31:0]                        m_axis_tdata,
    // tuser: transfer_kind
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);
    import sss_pkg::*;

    // Configuration registers.
    logic [SIZE_W-1:0] rank_size_reg;
    logic [POS_W-1:0]  my_cfg_reg;
    logic [POS_W-1:0]  root_cfg_reg;

    // Sequencer and working registers.
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   s_reg, s_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [2:0]          k_reg, k_next;
    logic [POS_W-1:0]    x_reg, x_next;
    logic [POS_W-1:0]    my_reg, my_next;
    logic [POS_W-1:0]    root_reg, root_next;
    logic [POS_W-1:0]    dmod_reg, dmod_next;
    logic [POS_W-1:0]    stride_reg, stride_next;
    logic [POS_W-1:0]    dr_reg, dr_next;
    logic [POS_W-1:0]    idx_reg, idx_next;
    logic [SLICE_W-1:0]  nsl_reg, nsl_next;
    logic [SLICE_W-1:0]  i_reg, i_next;
    kind_t               kind_reg, kind_next;
    logic [RANK_ID_WIDTH-1:0] peer_reg, peer_next;

    // Rank table and its registered read port.
    logic [RANK_ID_WIDTH-1:0] table_mem [MAX_RANKS];
    logic [RANK_ID_WIDTH-1:0] rd_reg;

    // Output register.
    logic                     ov_reg, ov_next;
    kind_t                    okind_reg, okind_next;
    logic [RANK_ID_WIDTH-1:0] opeer_reg, opeer_next;
    logic [SLICE_W-1:0]       oidx_reg, oidx_next;
    logic [SLICE_W-1:0]       ocnt_reg, ocnt_next;
    logic                     olast_reg, olast_next;

    // Shared compare-and-subtract unit.
    logic [UNIT_W-1:0] unit_a, unit_b, unit_y;

    logic [SIZE_W-1:0] r_eff;
    logic [UNIT_W-1:0] r_w;
    logic              perfect;
    logic              last_step;
    logic [8:0]        d_val;
    logic [8:0]        nranks;
    logic              do_send, do_recv;
    logic [8:0]        nsl_raw;
    logic [SLICE_W-1:0] nsl_calc;
    logic              in_acc, step_acc, load_acc;
    logic              out_free;
    logic              emit_last;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign step_acc = in_acc && (s_axis_tuser == ACTION_STEP);
    assign load_acc = in_acc && (s_axis_tuser == ACTION_LOAD);
    assign out_free = !ov_reg || m_axis_tready;

    // Rank count zero acts as one; counts above the table size saturate.
    always_comb
    begin
        if (rank_size_reg == '0)
            r_eff = SIZE_W'(1);
        else if (rank_size_reg > SIZE_W'(MAX_RANKS))
            r_eff = SIZE_W'(MAX_RANKS);
        else
            r_eff = rank_size_reg;
    end

    assign r_w     = UNIT_W'(r_eff);
    assign perfect = (r_eff & (r_eff - SIZE_W'(1))) == '0;
    assign unit_y  = (unit_a >= unit_b) ? (unit_a - unit_b) : unit_a;

    // Step decision, valid while the sequencer is in ST_PEER.
    always_comb
    begin
        d_val     = 9'd1 << s_reg;
        last_step = (cnt_reg != '0) && (s_reg == cnt_reg - STEP_W'(1));
        if (!perfect && last_step)
            nranks = (9'(r_eff) > d_val) ? (9'(r_eff) - d_val) : 9'd0;
        else
            nranks = d_val;
        do_send = 9'(dr_reg) < nranks;
        do_recv = (9'(dr_reg) >= d_val) && (10'(dr_reg) < (10'(nranks) + 10'(d_val)));
        nsl_raw = (9'(r_eff) - 9'd1 + d_val) >> (4'(s_reg) + 4'd1);
        if (!do_send && !do_recv)
            nsl_calc = '0;
        else if (nsl_raw > 9'(MAX_SLICES))
            nsl_calc = SLICE_W'(MAX_SLICES);
        else
            nsl_calc = nsl_raw[SLICE_W-1:0];
    end

    assign emit_last = (nsl_reg == '0) || (i_reg == nsl_reg - SLICE_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_acc)
                    state_next = ST_RED_MY;
            end
            ST_RED_MY:
            begin
                if (k_reg == '0)
                    state_next = ST_RED_ROOT;
            end
            ST_RED_ROOT:
            begin
                if (k_reg == '0)
                    state_next = ST_DOUBLE;
            end
            ST_DOUBLE:
            begin
                if (k_reg == '0)
                    state_next = ST_DIST;
            end
            ST_DIST:  state_next = ST_PEER;
            ST_PEER:  state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free && emit_last)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        s_next      = s_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        x_next      = x_reg;
        my_next     = my_reg;
        root_next   = root_reg;
        dmod_next   = dmod_reg;
        stride_next = stride_reg;
        dr_next     = dr_reg;
        idx_next    = idx_reg;
        nsl_next    = nsl_reg;
        i_next      = i_reg;
        kind_next   = kind_reg;
        peer_next   = peer_reg;
        unit_a      = '0;
        unit_b      = r_w;

        ov_next    = ov_reg && !m_axis_tready;
        okind_next = okind_reg;
        opeer_next = opeer_reg;
        oidx_next  = oidx_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_acc)
                begin
                    s_next   = s_axis_tdata[2:0];
                    cnt_next = s_axis_tdata[5:3];
                    x_next   = my_cfg_reg;
                    k_next   = 3'(POS_W - 1);
                end
            end
            ST_RED_MY, ST_RED_ROOT:
            begin
                // One restoring step of a position modulo the rank count.
                unit_a = UNIT_W'(x_reg);
                unit_b = r_w << k_reg;
                x_next = unit_y[POS_W-1:0];
                k_next = k_reg - 3'd1;
                if (k_reg == '0)
                begin
                    if (state_reg == ST_RED_MY)
                    begin
                        my_next = unit_y[POS_W-1:0];
                        x_next  = root_cfg_reg;
                        k_next  = 3'(POS_W - 1);
                    end
                    else
                    begin
                        root_next = unit_y[POS_W-1:0];
                        dmod_next = (r_eff == SIZE_W'(1)) ? '0 : POS_W'(1);
                        k_next    = s_reg;
                    end
                end
            end
            ST_DOUBLE:
            begin
                // Doubling modulo the rank count; the final doubling yields the stride.
                unit_a = UNIT_W'(dmod_reg) << 1;
                k_next = k_reg - 3'd1;
                if (k_reg == '0)
                    stride_next = unit_y[POS_W-1:0];
                else
                    dmod_next = unit_y[POS_W-1:0];
            end
            ST_DIST:
            begin
                unit_a  = UNIT_W'(root_reg) + r_w - UNIT_W'(my_reg);
                dr_next = unit_y[POS_W-1:0];
            end
            ST_PEER:
            begin
                if (do_send)
                    unit_a = UNIT_W'(my_reg) + r_w - UNIT_W'(dmod_reg);
                else
                    unit_a = UNIT_W'(my_reg) + UNIT_W'(dmod_reg);
                nsl_next = nsl_calc;
                i_next   = '0;
                if (do_send)
                begin
                    kind_next = KIND_SEND;
                    idx_next  = unit_y[POS_W-1:0];
                end
                else if (do_recv)
                begin
                    kind_next = KIND_RECV;
                    idx_next  = my_reg;
                end
                else
                begin
                    kind_next = KIND_IDLE;
                    idx_next  = '0;
                end
            end
            ST_LOOK:
            begin
                if (kind_reg == KIND_IDLE)
                    peer_next = RANK_ID_WIDTH'(r_eff);
                else
                    peer_next = rd_reg;
            end
            ST_EMIT:
            begin
                unit_a = UNIT_W'(idx_reg) + r_w - UNIT_W'(stride_reg);
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = kind_reg;
                    opeer_next = peer_reg;
                    oidx_next  = (nsl_reg == '0) ? '0 : idx_reg;
                    ocnt_next  = nsl_reg;
                    olast_next = emit_last;
                    idx_next   = unit_y[POS_W-1:0];
                    i_next     = i_reg + SLICE_W'(1);
                end
            end
            default:
            begin
                unit_a = '0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_size_reg <= SIZE_W'(1);
            my_cfg_reg    <= '0;
            root_cfg_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_RANK_SIZE: rank_size_reg <= cfg_wdata;
                REG_MY_RANK:   my_cfg_reg    <= cfg_wdata[POS_W-1:0];
                REG_ROOT_RANK: root_cfg_reg  <= cfg_wdata[POS_W-1:0];
                default:       ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        x_reg      <= x_next;
        my_reg     <= my_next;
        root_reg   <= root_next;
        dmod_reg   <= dmod_next;
        stride_reg <= stride_next;
        dr_reg     <= dr_next;
        idx_reg    <= idx_next;
        nsl_reg    <= nsl_next;
        i_reg      <= i_next;
        kind_reg   <= kind_next;
        peer_reg   <= peer_next;
        okind_reg  <= okind_next;
        opeer_reg  <= opeer_next;
        oidx_reg   <= oidx_next;
        ocnt_reg   <= ocnt_next;
        olast_reg  <= olast_next;
    end

    // Rank table: written by load beats, read once per step at the peer position.
    always_ff @(posedge clk)
    begin
        if (load_acc)
            table_mem[s_axis_tdata[11:6]] <= s_axis_tdata[27:12];
        if (state_reg == ST_PEER)
            rd_reg <= table_mem[unit_y[POS_W-1:0]];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {4'd0, ocnt_reg, oidx_reg, opeer_reg};
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;

`ifndef SYNTHESIS
    // Reduced positions must lie below the rank count once reduction is done.
    a_reduced_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIST) |-> (SIZE_W'(my_reg) < r_eff) && (SIZE_W'(root_reg) < r_eff))
        else $error("reduced position not below rank count");

    a_dist_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PEER) |-> (SIZE_W'(dmod_reg) < r_eff) && (SIZE_W'(stride_reg) < r_eff)
            && (SIZE_W'(dr_reg) < r_eff))
        else $error("distance or stride not below rank count");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((nsl_reg == '0) && (i_reg == '0)) || (i_reg < nsl_reg))
        else $error("slice counter ran past the slice count");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (okind_reg == KIND_IDLE)) |-> (ocnt_reg == '0) && olast_reg)
        else $error("idle result must carry no slices and be last");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(step_acc && rst_n) |-> (state_reg == ST_RED_MY) && !s_axis_tready)
        else $error("step beat did not start the sequencer");
`endif

endmodule
